>>> src/lsn_pkg.sv
// ----------------------------------------------------------------------------
// lsn_pkg
// Shared types and constants of the seven-point Laplacian stencil core.
// ----------------------------------------------------------------------------
package lsn_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int RESULT_W   = 33;
  localparam int MEAN_W     = 63;
  localparam int WEIGHT_W   = 16;
  localparam int DIM_CFG_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 64;

  // Stencil sum of 20-bit samples stays within 24 signed bits.
  localparam int ACC_W  = 24;
  localparam int MAG_W  = 23;
  localparam int PROD_W = 2 * MAG_W;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd4;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic        [MEAN_W-1:0]   mean_square;
    logic                       last;
  } out_item_t;

  // Classification handed from the front end to the back end.
  typedef struct packed {
    logic emit;
    logic store;
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
    logic last;
  } entry_flags_t;

endpackage

>>> src/lsn_queue.sv
// ----------------------------------------------------------------------------
// lsn_queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lsn_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> src/lsn_front.sv
// ----------------------------------------------------------------------------
// lsn_front
// Configuration registers, volume geometry and item classification.
// ----------------------------------------------------------------------------
module lsn_front #(
  parameter int MAX_DIM_X = 128,
  parameter int MAX_DIM_Y = 128,
  parameter int MAX_DIM_Z = 128,
  parameter int DX_W      = 8,
  parameter int PL_W      = 15,
  parameter int POS_W     = 22
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lsn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsn_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  input  lsn_pkg::in_item_t                  in_item,
  output logic                               in_ready,
  input  logic                               q_full,
  output logic                               q_push,
  output lsn_pkg::entry_flags_t              q_flags,
  output logic [POS_W-1:0]                   q_p,
  output logic [POS_W-1:0]                   q_q,
  output logic signed [lsn_pkg::SAMPLE_W-1:0] q_val,
  output logic [DX_W-1:0]                    row,
  output logic [PL_W-1:0]                    plane,
  output logic [POS_W-1:0]                   total,
  output logic                               mode,
  output logic [lsn_pkg::WEIGHT_W-1:0]       weight,
  output logic                               restart
);
  import lsn_pkg::*;

  localparam int DY_W = $clog2(MAX_DIM_Y + 1);
  localparam int DZ_W = $clog2(MAX_DIM_Z + 1);

  logic [DIM_CFG_W-1:0] dim_x_r, dim_y_r, dim_z_r;
  logic                 mode_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [1:0]           settle_r;
  logic [PL_W-1:0]      plane_r;
  logic [POS_W-1:0]     total_r;
  logic [DX_W-1:0]      dx;
  logic [DY_W-1:0]      dy;
  logic [DZ_W-1:0]      dz;

  logic [POS_W-1:0] iq_r, iq_nxt, ip_r, ip_nxt;
  logic [DX_W-1:0]  x_r, x_nxt;
  logic [DY_W-1:0]  y_r, y_nxt;
  logic [DZ_W-1:0]  z_r, z_nxt;
  logic             accept, is_push, do_store, do_emit, is_last;

  always_comb begin
    if (int'(dim_x_r) > MAX_DIM_X) dx = DX_W'(MAX_DIM_X);
    else if (dim_x_r < 8'd2)       dx = DX_W'(2);
    else                           dx = DX_W'(dim_x_r);
    if (int'(dim_y_r) > MAX_DIM_Y) dy = DY_W'(MAX_DIM_Y);
    else if (dim_y_r < 8'd2)       dy = DY_W'(2);
    else                           dy = DY_W'(dim_y_r);
    if (int'(dim_z_r) > MAX_DIM_Z) dz = DZ_W'(MAX_DIM_Z);
    else if (dim_z_r < 8'd2)       dz = DZ_W'(2);
    else                           dz = DZ_W'(dim_z_r);
  end

  assign restart = cfg_we && (cfg_index == CFG_DIM_X || cfg_index == CFG_DIM_Y ||
                              cfg_index == CFG_DIM_Z || cfg_index == CFG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r  <= 8'd128;
      dim_y_r  <= 8'd128;
      dim_z_r  <= 8'd128;
      mode_r   <= 1'b0;
      weight_r <= 16'd256;
      settle_r <= 2'd2;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIM_X:  dim_x_r  <= cfg_wdata[DIM_CFG_W-1:0];
          CFG_DIM_Y:  dim_y_r  <= cfg_wdata[DIM_CFG_W-1:0];
          CFG_DIM_Z:  dim_z_r  <= cfg_wdata[DIM_CFG_W-1:0];
          CFG_MODE:   mode_r   <= cfg_wdata[0];
          CFG_WEIGHT: weight_r <= cfg_wdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      // Plane size and voxel count settle through two registered products.
      if (restart) settle_r <= 2'd2;
      else if (settle_r != 2'd0) settle_r <= settle_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= PL_W'(dx) * PL_W'(dy);
    total_r <= POS_W'(plane_r) * POS_W'(dz);
  end

  assign row    = dx;
  assign plane  = plane_r;
  assign total  = total_r;
  assign mode   = mode_r;
  assign weight = weight_r;

  assign in_ready = (settle_r == 2'd0) && !q_full;
  assign accept   = in_valid && in_ready;
  assign is_push  = (in_item.opcode == OP_PUSH);
  assign is_last  = (ip_r == total_r - 1'b1);

  always_comb begin
    do_store = 1'b0;
    do_emit  = 1'b0;
    if (is_push) begin
      if (iq_r < total_r) begin
        do_store = 1'b1;
        do_emit  = (iq_r >= POS_W'(plane_r));
      end
    end else begin
      do_emit = (iq_r == total_r) && (ip_r < total_r);
    end
  end

  always_comb begin
    iq_nxt = iq_r;
    ip_nxt = ip_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    z_nxt  = z_r;
    if (accept) begin
      if (do_store) iq_nxt = iq_r + 1'b1;
      if (do_emit) begin
        ip_nxt = ip_r + 1'b1;
        if (x_r == dx - 1'b1) begin
          x_nxt = '0;
          if (y_r == dy - 1'b1) begin
            y_nxt = '0;
            z_nxt = z_r + 1'b1;
          end else begin
            y_nxt = y_r + 1'b1;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
        if (is_last) begin
          iq_nxt = '0;
          ip_nxt = '0;
          x_nxt  = '0;
          y_nxt  = '0;
          z_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      iq_r <= '0;
      ip_r <= '0;
      x_r  <= '0;
      y_r  <= '0;
      z_r  <= '0;
    end else begin
      iq_r <= iq_nxt;
      ip_r <= ip_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
    end
  end

  assign q_push        = accept && (do_store || do_emit);
  assign q_flags.emit  = do_emit;
  assign q_flags.store = do_store;
  assign q_flags.x_lo  = (x_r == '0);
  assign q_flags.x_hi  = (x_r == dx - 1'b1);
  assign q_flags.y_lo  = (y_r == '0);
  assign q_flags.y_hi  = (y_r == dy - 1'b1);
  assign q_flags.z_lo  = (z_r == '0);
  assign q_flags.z_hi  = (z_r == dz - 1'b1);
  assign q_flags.last  = do_emit && is_last;
  assign q_p           = ip_r;
  assign q_q           = iq_r;
  assign q_val         = in_item.sample_value;

endmodule

>>> src/lsn_back.sv
// ----------------------------------------------------------------------------
// lsn_back
// Plane store, stencil accumulation, square sum, divider and result register.
// ----------------------------------------------------------------------------
module lsn_back #(
  parameter int DX_W   = 8,
  parameter int PL_W   = 15,
  parameter int POS_W  = 22,
  parameter int ADDR_W = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  lsn_pkg::entry_flags_t               q_flags,
  input  logic [POS_W-1:0]                    q_p,
  input  logic [POS_W-1:0]                    q_q,
  input  logic signed [lsn_pkg::SAMPLE_W-1:0] q_val,
  input  logic [DX_W-1:0]                     row,
  input  logic [PL_W-1:0]                     plane,
  input  logic [POS_W-1:0]                    total,
  input  logic                                mode,
  input  logic [lsn_pkg::WEIGHT_W-1:0]        weight,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lsn_pkg::out_item_t                  out_item
);
  import lsn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_CALC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  localparam logic [2:0] K_CENTRE = 3'd6;
  localparam logic [2:0] K_END    = 3'd7;

  state_t state_r;

  logic signed [SAMPLE_W-1:0] mem [2**ADDR_W];
  logic signed [SAMPLE_W-1:0] rd_val_r, wr_data;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                       wr_en, rd_en;

  entry_flags_t               flg_r;
  logic [POS_W-1:0]           p_r, q_r;
  logic signed [SAMPLE_W-1:0] val_r;
  logic [2:0]                 k_r;
  logic                       byp_d_r, cen_d_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       neg_r;
  logic [MAG_W-1:0]           mag_r;
  logic [PROD_W-1:0]          prod_r;
  logic [SUM_W-1:0]           sum_r;
  logic [SUM_W-1:0]           dvd_r;
  logic [POS_W-1:0]           rem_r;
  logic [5:0]                 cnt_r;
  logic signed [RESULT_W-1:0] res_r;
  logic                       out_valid_r;
  out_item_t                  out_r;

  logic [POS_W-1:0]           row_e, pl_e, pos_k;
  logic signed [SAMPLE_W-1:0] v_sel;
  logic signed [ACC_W-1:0]    v_ext, term;
  logic [ACC_W-1:0]           mag_full;
  logic [SUM_W:0]             sum_add;
  logic [SUM_W-1:0]           sum_new;
  logic [POS_W:0]             rem_sh, rem_sub;
  logic                       ge;
  logic signed [RESULT_W-1:0] quo_s;
  logic                       out_load;

  assign row_e = POS_W'(row);
  assign pl_e  = POS_W'(plane);

  // Neighbour order: x-1, x+1, y-1, y+1, z-1, z+1, centre; borders reflect.
  always_comb begin
    unique case (k_r)
      3'd0:    pos_k = flg_r.x_lo ? p_r + 1'b1 : p_r - 1'b1;
      3'd1:    pos_k = flg_r.x_hi ? p_r - 1'b1 : p_r + 1'b1;
      3'd2:    pos_k = flg_r.y_lo ? p_r + row_e : p_r - row_e;
      3'd3:    pos_k = flg_r.y_hi ? p_r - row_e : p_r + row_e;
      3'd4:    pos_k = flg_r.z_lo ? p_r + pl_e : p_r - pl_e;
      3'd5:    pos_k = flg_r.z_hi ? p_r - pl_e : p_r + pl_e;
      default: pos_k = p_r;
    endcase
  end

  assign rd_addr = pos_k[ADDR_W-1:0];
  assign rd_en   = (state_r == S_READ) && (k_r != K_END);
  assign q_pop   = (state_r == S_IDLE) && !q_empty;

  // The incoming voxel is written only after its own stencil reads.
  always_comb begin
    if (state_r == S_IDLE) begin
      wr_en   = q_pop && q_flags.store && !q_flags.emit;
      wr_addr = q_q[ADDR_W-1:0];
      wr_data = q_val;
    end else begin
      wr_en   = (state_r == S_READ) && (k_r == K_END) && flg_r.store;
      wr_addr = q_r[ADDR_W-1:0];
      wr_data = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val_r <= mem[rd_addr];
    end
  end

  assign v_sel    = byp_d_r ? val_r : rd_val_r;
  assign v_ext    = ACC_W'(v_sel);
  assign term     = cen_d_r ? -((v_ext <<< 2) + (v_ext <<< 1)) : v_ext;
  assign mag_full = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(prod_r);
  assign sum_new  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign rem_sh   = {rem_r, dvd_r[SUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, total};
  assign ge       = (rem_sh >= {1'b0, total});
  assign quo_s    = neg_r ? -RESULT_W'(dvd_r) : RESULT_W'(dvd_r);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && q_flags.emit) begin
            flg_r   <= q_flags;
            p_r     <= q_p;
            q_r     <= q_q;
            val_r   <= q_val;
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (k_r != 3'd0) acc_r <= acc_r + term;
          byp_d_r <= flg_r.store && (pos_k == q_r);
          cen_d_r <= (k_r == K_CENTRE);
          if (k_r == K_END) state_r <= S_CALC;
          else k_r <= k_r + 1'b1;
        end
        S_CALC: begin
          neg_r   <= acc_r[ACC_W-1];
          mag_r   <= mag_full[MAG_W-1:0];
          res_r   <= RESULT_W'(acc_r);
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mode) prod_r <= PROD_W'(weight) * PROD_W'(mag_r);
          else      prod_r <= PROD_W'(mag_r) * PROD_W'(mag_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          rem_r <= '0;
          cnt_r <= '0;
          if (mode) begin
            // 2*w*|s|/(256*N) equals ((w*|s|) >> 7) / N.
            dvd_r   <= SUM_W'(prod_r >> 7);
            state_r <= S_DIV;
          end else begin
            sum_r <= sum_new;
            dvd_r <= sum_new;
            if (flg_r.last) state_r <= S_DIV;
            else            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          rem_r <= ge ? rem_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
          dvd_r <= {dvd_r[SUM_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            if (flg_r.last) sum_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (clear) sum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.result_value <= mode ? quo_s : res_r;
      out_r.mean_square  <= (!mode && flg_r.last) ? dvd_r[MEAN_W-1:0] : '0;
      out_r.last         <= flg_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> src/laplacian_stencil_3d_norm_core.sv
// ----------------------------------------------------------------------------
// laplacian_stencil_3d_norm_core
// Streaming seven-point 3D Laplacian with mean-square norm and gradient step.
// ----------------------------------------------------------------------------
// Voxels are pushed in raster order; each result appears once the voxel one
// plane ahead has arrived, and the final plane is flushed with drain items.
// The front end takes one item per cycle, while the queue is not full, into a
// four-entry queue. The back end retires a store-only voxel straight from its
// idle state; a voxel that yields a result takes seven reads through the single
// read port of the plane store, and the final result of a volume in mode 0 and
// every result in mode 1 also pass through the bit-serial divider. After reset
// and after a write to a dimension or the mode register, input is held off
// while the plane size and voxel count are recomputed.
module laplacian_stencil_3d_norm_core #(
  parameter int MAX_DIM_X = 128,
  parameter int MAX_DIM_Y = 128,
  parameter int MAX_DIM_Z = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lsn_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lsn_pkg::out_item_t             out_item
);
  import lsn_pkg::*;

  localparam int DX_W   = $clog2(MAX_DIM_X + 1);
  localparam int PL_W   = $clog2(MAX_DIM_X * MAX_DIM_Y + 1);
  localparam int POS_W  = $clog2(MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z + 1);
  localparam int ADDR_W = $clog2(2 * MAX_DIM_X * MAX_DIM_Y);
  localparam int FLG_W  = $bits(entry_flags_t);
  localparam int ENT_W  = FLG_W + 2 * POS_W + SAMPLE_W;
  localparam int Q_DEPTH = 4;

  entry_flags_t               f_flags, b_flags;
  logic [POS_W-1:0]           f_p, f_q, b_p, b_q, total;
  logic signed [SAMPLE_W-1:0] f_val, b_val;
  logic [DX_W-1:0]            row;
  logic [PL_W-1:0]            plane;
  logic                       mode, restart;
  logic [WEIGHT_W-1:0]        weight;
  logic                       q_push, q_pop, q_full, q_empty;
  logic [ENT_W-1:0]           q_din, q_dout;

  lsn_front #(
    .MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z),
    .DX_W(DX_W), .PL_W(PL_W), .POS_W(POS_W)
  ) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_item, .in_ready,
    .q_full, .q_push, .q_flags(f_flags), .q_p(f_p), .q_q(f_q), .q_val(f_val),
    .row, .plane, .total, .mode, .weight, .restart
  );

  assign q_din = {f_flags, f_p, f_q, f_val};
  assign {b_flags, b_p, b_q, b_val} = q_dout;

  lsn_queue #(.W(ENT_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .din(q_din), .pop(q_pop), .dout(q_dout),
    .full(q_full), .empty(q_empty)
  );

  lsn_back #(
    .DX_W(DX_W), .PL_W(PL_W), .POS_W(POS_W), .ADDR_W(ADDR_W)
  ) u_back (
    .clk, .rst_n, .clear(restart), .q_empty, .q_pop,
    .q_flags(b_flags), .q_p(b_p), .q_q(b_q), .q_val(b_val),
    .row, .plane, .total, .mode, .weight,
    .out_valid, .out_ready, .out_item
  );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the seven-point 3D Laplacian stencil core.
// ----------------------------------------------------------------------------
// Volumes of voxels are streamed through the core in raster order, with drain
// items to flush the last plane. A behavioral predictor of the stencil, the
// mean-square norm and the gradient increment runs alongside. Every returned
// item is compared field by field with the oldest predicted one. Both sides of
// the stream idle and stall at random.
module tb_top;
  import lsn_pkg::*;

  localparam int MAX_D      = 128;
  localparam int DEPTH      = 2 * MAX_D * MAX_D;
  localparam int CFG_SETTLE = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  laplacian_stencil_3d_norm_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #6 clk = ~clk;

  // Mirror of the core's state.
  logic signed [SAMPLE_W-1:0] voxel_mem [DEPTH];
  int unsigned       push_pos, emit_pos;
  longint unsigned   sq_sum;
  int unsigned       reg_dx = 128, reg_dy = 128, reg_dz = 128, reg_mode = 0;
  longint unsigned   reg_weight = 256;

  out_item_t expected_q[$];
  int  send_idle_pct = 0, recv_stall_pct = 0;
  int  items_sent = 0, results_seen = 0, volumes_run = 0, mismatches = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    return (v < 2) ? 2 : ((v > MAX_D) ? MAX_D : v);
  endfunction

  function automatic longint voxel_at(int unsigned pos, bit has_new, int unsigned new_pos,
                                      longint new_val);
    if (has_new && pos == new_pos) return new_val;
    return voxel_mem[pos % DEPTH];
  endfunction

  function automatic out_item_t stencil_result(bit has_new, int unsigned new_pos,
                                               longint new_val);
    int unsigned dx, dy, dz, pl, total, p, x, y, z;
    int unsigned xm, xp, ym, yp, zm, zp;
    longint s, r;
    longint unsigned mag, sq, mean, num, q;
    bit neg, is_last;
    out_item_t res;
    dx = clamp_dim(reg_dx); dy = clamp_dim(reg_dy); dz = clamp_dim(reg_dz);
    pl = dx * dy; total = pl * dz; p = emit_pos;
    x = p % dx; y = (p / dx) % dy; z = p / pl;
    // A missing neighbor is mirrored from the opposite side.
    xm = (x > 0) ? p - 1 : p + 1;
    xp = (x + 1 < dx) ? p + 1 : p - 1;
    ym = (y > 0) ? p - dx : p + dx;
    yp = (y + 1 < dy) ? p + dx : p - dx;
    zm = (z > 0) ? p - pl : p + pl;
    zp = (z + 1 < dz) ? p + pl : p - pl;
    s = voxel_at(xm, has_new, new_pos, new_val) + voxel_at(xp, has_new, new_pos, new_val)
      + voxel_at(ym, has_new, new_pos, new_val) + voxel_at(yp, has_new, new_pos, new_val)
      + voxel_at(zm, has_new, new_pos, new_val) + voxel_at(zp, has_new, new_pos, new_val)
      - 6 * voxel_at(p, has_new, new_pos, new_val);
    neg = s < 0;
    mag = neg ? -s : s;
    is_last = (p + 1 == total);
    mean = 0;
    if (reg_mode == 0) begin
      sq = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
      sq_sum = (sq_sum > ~64'd0 - sq) ? '1 : sq_sum + sq;
      r = s;
      if (is_last) begin
        mean = sq_sum / total;
        if (mean > 64'h7FFF_FFFF_FFFF_FFFF) mean = 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end else begin
      num = 2 * reg_weight * mag;
      q = num / (256 * longint'(total));
      if (q > 64'h1_FFFF_FFFF) q = 64'h1_FFFF_FFFF;
      r = neg ? -longint'(q) : longint'(q);
    end
    if (r > 64'sd4294967295) r = 64'sd4294967295;
    if (r < -64'sd4294967296) r = -64'sd4294967296;
    res.result_value = r[RESULT_W-1:0];
    res.mean_square  = mean[MEAN_W-1:0];
    res.last         = is_last;
    emit_pos++;
    if (is_last) begin
      push_pos = 0; emit_pos = 0; sq_sum = 0;
    end
    return res;
  endfunction

  // Applies one accepted item to the mirror and queues any result it causes.
  function automatic void predict_item(in_item_t it);
    int unsigned pl, total;
    longint v;
    pl = clamp_dim(reg_dx) * clamp_dim(reg_dy);
    total = pl * clamp_dim(reg_dz);
    v = it.sample_value;
    if (it.opcode == OP_PUSH) begin
      if (push_pos >= total) return;
      if (push_pos >= pl)
        expected_q.insert(expected_q.size(), stencil_result(1'b1, push_pos, v));
      voxel_mem[push_pos % DEPTH] = it.sample_value;
      push_pos++;
    end else if (push_pos == total && emit_pos < total) begin
      expected_q.insert(expected_q.size(), stencil_result(1'b0, 0, 0));
    end
  endfunction

  // Called at a rising edge; returns just after the edge that accepts the item.
  task automatic send_item(logic op, logic signed [SAMPLE_W-1:0] val);
    in_item_t it;
    it.opcode = op;
    it.sample_value = val;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  task automatic wait_results;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    wait_results();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DIM_X:  reg_dx = val & 8'hFF;
      CFG_DIM_Y:  reg_dy = val & 8'hFF;
      CFG_DIM_Z:  reg_dz = val & 8'hFF;
      CFG_MODE:   reg_mode = val & 1;
      CFG_WEIGHT: reg_weight = val & 16'hFFFF;
      default: ;
    endcase
    if (idx != CFG_WEIGHT) begin
      push_pos = 0; emit_pos = 0; sq_sum = 0;
    end
  endtask

  task automatic set_volume(int unsigned dx, int unsigned dy, int unsigned dz,
                            int unsigned mode, int unsigned weight);
    write_reg(CFG_DIM_X, dx);
    write_reg(CFG_DIM_Y, dy);
    write_reg(CFG_DIM_Z, dz);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_WEIGHT, weight);
    volumes_run++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(5))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return SAMPLE_W'($signed($urandom_range(15)) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Streams one whole volume with the current settings, optionally with noise.
  task automatic stream_volume(bit noisy);
    int unsigned pl, total;
    pl = clamp_dim(reg_dx) * clamp_dim(reg_dy);
    total = pl * clamp_dim(reg_dz);
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(19) == 0) send_item(OP_DRAIN, SAMPLE_W'($urandom()));
      send_item(OP_PUSH, pick_sample());
    end
    if (noisy && $urandom_range(3) == 0) send_item(OP_PUSH, SAMPLE_W'($urandom()));
    for (int unsigned i = 0; i < pl; i++) send_item(OP_DRAIN, SAMPLE_W'($urandom()));
    if (noisy && $urandom_range(3) == 0) send_item(OP_DRAIN, SAMPLE_W'($urandom()));
  endtask

  task automatic test_directed;
    // Smallest volume: every voxel sits on all borders; extreme samples.
    set_volume(2, 2, 2, 0, 256);
    send_item(OP_PUSH, {1'b0, {(SAMPLE_W-1){1'b1}}});
    send_item(OP_DRAIN, '0);
    for (int i = 0; i < 7; i++) send_item(OP_PUSH, (i % 2) ? {1'b1, {(SAMPLE_W-1){1'b0}}} : '0);
    send_item(OP_PUSH, 20'h12345);
    for (int i = 0; i < 5; i++) send_item(OP_DRAIN, '1);
    // Gradient increment with the largest weight, then with zero weight.
    set_volume(0, 1, 2, 1, 16'hFFFF);
    stream_volume(1'b0);
    write_reg(CFG_WEIGHT, 0);
    stream_volume(1'b0);
  endtask

  task automatic test_abort_and_clamp;
    // A dimension write in the middle of a volume starts a new one.
    set_volume(3, 2, 2, 0, 256);
    for (int i = 0; i < 8; i++) send_item(OP_PUSH, pick_sample());
    write_reg(CFG_DIM_Z, 2);
    stream_volume(1'b0);
    // The clamped row width is exercised over more than one row of results,
    // and the partial volume is then dropped by the next setup.
    set_volume(255, 2, 2, 0, 256);
    for (int i = 0; i < 400; i++) send_item(OP_PUSH, pick_sample());
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int target);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      set_volume($urandom_range(5, 2), $urandom_range(4, 1), $urandom_range(4, 2),
                 $urandom_range(1), ($urandom_range(3) == 0) ? 16'hFFFF : $urandom());
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(20, 1)) send_item(1'($urandom_range(1)), pick_sample());
      end else begin
        stream_volume(1'b1);
      end
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Outputs are sampled mid-cycle; the item moves at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_item);
      end else begin
        out_item_t want;
        want = expected_q.pop_front();
        if (out_item.result_value !== want.result_value ||
            out_item.mean_square !== want.mean_square || out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected val=%0d mean=%0d last=%0b, got val=%0d mean=%0d last=%0b",
                     want.result_value, want.mean_square, want.last,
                     out_item.result_value, out_item.mean_square, out_item.last);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_abort_and_clamp();
    test_random(36, 64, 300);
    test_random(64, 36, 300);
    test_random(0, 0, 300);
    wait_results();
    repeat (CFG_SETTLE) @(posedge clk);
    $display("Streamed %0d items over %0d volume setups, %0d results checked.",
             items_sent, volumes_run, results_seen);
    $display("Covered both modes, border mirroring, clamped sizes, aborts and drains.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
